### src/ille_pkg.sv
// Shared types and codes for the indexed linked list engine.
package ille_pkg;

  // Link width: slot indexes plus the null marker
  localparam int unsigned LINK_W = 7;
  localparam int unsigned VAL_W  = 32;
  localparam logic [LINK_W-1:0] NIL_LINK = 7'd127;

  // Operation codes
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_DUMP   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0]              operation;
    logic [LINK_W-1:0]       position;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] out_value;
    logic                    last;
  } res_t;

  // Node table access for one cycle
  typedef struct packed {
    logic              val_we;
    logic              lnk_we;
    logic [LINK_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_val;
    logic [LINK_W-1:0] wr_lnk;
    logic [LINK_W-1:0] rd_addr;
  } node_req_t;

endpackage

### src/indexed_linked_list_engine_unit.sv
// Top level: sequencer of the linked list engine over a shared node table.
//
//  Channel  | Ports                    | Transfer
//  ---------+--------------------------+------------------------------------
//  command  | start_i, cmd_i, busy_o   | start_i high and busy_o low at edge
//  result   | res_valid_o, res_o       | one cycle per result, no stall
//
// Push and failing operations finish in S_EXEC; insert and delete of an
// inner node go on to S_FIX or S_DEL2; a dump emits one result per node
// walked (up to CAPACITY). The single read port of the node table sets these
// steps: each list step waits for one registered read. Reset empties the list
// at once, no sweep. The result side has no backpressure; busy_o drops in the
// cycle that shows the final result of an item.
module indexed_linked_list_engine_unit import ille_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  cmd_t cmd_i,
  output logic busy_o,
  output logic res_valid_o,
  output res_t res_o
);

  localparam logic [LINK_W-1:0] CAP_L  = LINK_W'(CAPACITY);
  localparam logic [LINK_W-1:0] LAST_N = LINK_W'(CAPACITY - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_FIX  = 3'd2;
  localparam logic [2:0] S_DEL2 = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;

  logic [2:0]        state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [LINK_W-1:0] head_q, head_d;
  logic [LINK_W-1:0] used_q, used_d;
  logic [LINK_W-1:0] cnt_q, cnt_d;
  logic              res_valid_q, res_valid_d;
  res_t              res_q, res_d;
  node_req_t         req;
  logic [VAL_W-1:0]  rd_val;
  logic [LINK_W-1:0] rd_lnk;
  logic              accept;
  logic [LINK_W-1:0] ref_idx;
  logic              walk_end;

  ille_node_table #(.CAPACITY(CAPACITY)) u_table (
    .clk_i    (clk_i),
    .req_i    (req),
    .rd_val_o (rd_val),
    .rd_lnk_o (rd_lnk)
  );

  assign accept   = start_i && (state_q == S_IDLE);
  assign ref_idx  = cmd_q.position - LINK_W'(1);
  assign walk_end = (rd_lnk >= CAP_L) || (cnt_q == LAST_N);

  // Sequence one command through the node table
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    head_d      = head_q;
    used_d      = used_q;
    cnt_d       = cnt_q;
    res_valid_d = 1'b0;
    res_d       = '{status: ST_OK, out_value: '0, last: 1'b1};
    req         = '{val_we: 1'b0, lnk_we: 1'b0, wr_addr: used_q, wr_val: cmd_q.value,
                    wr_lnk: head_q, rd_addr: '0};
    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.operation == OP_DUMP ||
            (cmd_i.operation == OP_DELETE && cmd_i.position == '0)) begin
          req.rd_addr = head_q;
        end else begin
          req.rd_addr = cmd_i.position - LINK_W'(1);
        end
        if (accept) begin
          cmd_d = cmd_i;
          cnt_d = '0;
          if (cmd_i.operation == OP_DUMP && head_q < CAP_L) begin
            state_d = S_WALK;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        state_d     = S_IDLE;
        res_valid_d = 1'b1;
        unique case (cmd_q.operation)
          OP_PUSH: begin
            if (used_q >= CAP_L) begin
              res_d.status = ST_FULL;
            end else begin
              req.val_we = 1'b1;
              req.lnk_we = 1'b1;
              head_d     = used_q;
              used_d     = used_q + LINK_W'(1);
            end
          end
          OP_INSERT: begin
            if (cmd_q.position == '0 || cmd_q.position > used_q) begin
              res_d.status = ST_BADPOS;
            end else if (used_q >= CAP_L) begin
              res_d.status = ST_FULL;
            end else begin
              // New node takes the reference node's link
              req.val_we  = 1'b1;
              req.lnk_we  = 1'b1;
              req.wr_lnk  = rd_lnk;
              used_d      = used_q + LINK_W'(1);
              res_valid_d = 1'b0;
              state_d     = S_FIX;
            end
          end
          OP_DELETE: begin
            if (cmd_q.position == '0) begin
              if (head_q >= CAP_L) begin
                res_d.status = ST_NONE;
              end else begin
                head_d = rd_lnk;
              end
            end else if (cmd_q.position > used_q) begin
              res_d.status = ST_BADPOS;
            end else if (rd_lnk >= CAP_L) begin
              res_d.status = ST_NONE;
            end else begin
              // Fetch the victim's link
              req.rd_addr = rd_lnk;
              res_valid_d = 1'b0;
              state_d     = S_DEL2;
            end
          end
          OP_DUMP: begin
            res_d.status = ST_NONE;
          end
          default: begin
            res_d.status = ST_NONE;
          end
        endcase
      end
      S_FIX: begin
        // Point the reference node at the new node
        req.lnk_we  = 1'b1;
        req.wr_addr = ref_idx;
        req.wr_lnk  = used_q - LINK_W'(1);
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      S_DEL2: begin
        // Bypass the victim
        req.lnk_we  = 1'b1;
        req.wr_addr = ref_idx;
        req.wr_lnk  = rd_lnk;
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      S_WALK: begin
        // Emit the current node and fetch the next one
        req.rd_addr     = rd_lnk;
        res_valid_d     = 1'b1;
        res_d.out_value = rd_val;
        res_d.last      = walk_end;
        cnt_d           = cnt_q + LINK_W'(1);
        if (walk_end) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= NIL_LINK;
      used_q      <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      used_q      <= used_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    res_q <= res_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CAP_L)
    else $error("node count above capacity");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == NIL_LINK) || (head_q < used_q))
    else $error("head points at an unused slot");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.last) |-> !busy_o)
    else $error("busy after final result");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (cnt_q < CAP_L))
    else $error("dump walked past capacity");

  a_one_shot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && state_q != S_WALK && !$past(state_q == S_WALK)) |-> res_q.last)
    else $error("non-dump result without last");
`endif

endmodule

### src/ille_node_table.sv
// Node table: value and link memories with one write address and one registered read.
module ille_node_table import ille_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic              clk_i,
  input  node_req_t         req_i,
  output logic [VAL_W-1:0]  rd_val_o,
  output logic [LINK_W-1:0] rd_lnk_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [VAL_W-1:0]  val_mem [CAPACITY];
  logic [LINK_W-1:0] lnk_mem [CAPACITY];
  logic [VAL_W-1:0]  rd_val_q;
  logic [LINK_W-1:0] rd_lnk_q;

  // Write the addressed node, read the requested one
  always_ff @(posedge clk_i) begin
    if (req_i.val_we) begin
      val_mem[req_i.wr_addr[AW-1:0]] <= req_i.wr_val;
    end
    if (req_i.lnk_we) begin
      lnk_mem[req_i.wr_addr[AW-1:0]] <= req_i.wr_lnk;
    end
    rd_val_q <= val_mem[req_i.rd_addr[AW-1:0]];
    rd_lnk_q <= lnk_mem[req_i.rd_addr[AW-1:0]];
  end

  assign rd_val_o = rd_val_q;
  assign rd_lnk_o = rd_lnk_q;

endmodule
